[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[hw/rtl/ssee_pkg.sv]
// Shared types, constants and arithmetic helpers of the state-space Euler stepper.
package ssee_pkg;

    localparam int MAX_STATES  = 4;
    localparam int MAX_DRIVES  = 2;
    localparam int MAX_OUTPUTS = 4;

    localparam int A_BASE     = 0;
    localparam int B_BASE     = A_BASE + MAX_STATES * MAX_STATES;
    localparam int C_BASE     = B_BASE + MAX_STATES * MAX_DRIVES;
    localparam int D_BASE     = C_BASE + MAX_OUTPUTS * MAX_STATES;
    localparam int COEF_COUNT = D_BASE + MAX_OUTPUTS * MAX_DRIVES;
    localparam int CA_W       = $clog2(COEF_COUNT);

    localparam int IDX_W  = 2;   // element index width (fixed by the word fields)
    localparam int N_W    = 3;   // width of the size counts
    localparam int PROD_W = 48;  // Q4.12 x Q16.16
    localparam int ACC_W  = PROD_W + $clog2(MAX_STATES + MAX_DRIVES);
    localparam int XD_W   = 49;  // Q16.16 x unsigned Q0.16
    localparam int UPC_W  = 5;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2048);
    localparam logic signed [XD_W-1:0]  XD_HALF  = XD_W'(32768);

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR    = 4'd1;
    localparam logic [OP_W-1:0] OP_ISS_A  = 4'd2;
    localparam logic [OP_W-1:0] OP_ISS_B  = 4'd3;
    localparam logic [OP_W-1:0] OP_ISS_C  = 4'd4;
    localparam logic [OP_W-1:0] OP_ISS_D  = 4'd5;
    localparam logic [OP_W-1:0] OP_RND    = 4'd6;
    localparam logic [OP_W-1:0] OP_DTMUL  = 4'd7;
    localparam logic [OP_W-1:0] OP_INC    = 4'd8;
    localparam logic [OP_W-1:0] OP_UPD    = 4'd9;
    localparam logic [OP_W-1:0] OP_COMMIT = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT_Y = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT_X = 4'd12;

    // sequencer branch conditions
    localparam int CND_W = 3;
    localparam logic [CND_W-1:0] CND_NEXT = 3'd0;
    localparam logic [CND_W-1:0] CND_GO   = 3'd1;
    localparam logic [CND_W-1:0] CND_JN   = 3'd2;
    localparam logic [CND_W-1:0] CND_JM   = 3'd3;
    localparam logic [CND_W-1:0] CND_IN   = 3'd4;
    localparam logic [CND_W-1:0] CND_IP   = 3'd5;
    localparam logic [CND_W-1:0] CND_JMP  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [UPC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_dp_ctrl;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] m;
        logic [N_W-1:0] p;
    } t_dims;

    typedef struct packed {
        logic               coef_we;
        logic [5:0]         coef_idx;
        logic signed [15:0] coef_val;
        logic               state_we;
        logic [1:0]         state_idx;
        logic signed [31:0] state_val;
        logic               drive_ld;
        logic signed [31:0] drive_a;
        logic signed [31:0] drive_b;
    } t_wr;

    typedef struct packed {
        logic               emit;
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] sample;
        logic               last;
    } t_result;

    function automatic logic [N_W-1:0] clamp_count(input logic [N_W-1:0] v, input int maxv);
        if (v == '0) return N_W'(1);
        if (int'(v) > maxv) return N_W'(maxv);
        return v;
    endfunction

    // round half up at bit 12, then saturate to 32 bits
    function automatic logic signed [31:0] sat_rnd12(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + ACC_HALF) >>> 12;
        if (t[ACC_W-1:31] == '0 || t[ACC_W-1:31] == '1) return t[31:0];
        return t[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic signed [31:0] sat_x34(input logic signed [33:0] a);
        if (a[33:31] == '0 || a[33:31] == '1) return a[31:0];
        return a[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

[hw/rtl/ssee_in_if.sv]
// Input channel: command words for the stepper.
interface ssee_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [1:0]         state_index;
    logic signed [31:0] state_value;
    logic signed [31:0] drive_a;
    logic signed [31:0] drive_b;

    modport source (output valid, action, coef_index, coef_value, state_index,
                    state_value, drive_a, drive_b, input ready);
    modport sink   (input valid, action, coef_index, coef_value, state_index,
                    state_value, drive_a, drive_b, output ready);
endinterface

[hw/rtl/ssee_out_if.sv]
// Output channel: result words of a step.
interface ssee_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         element_index;
    logic signed [31:0] sample;
    logic               last;

    modport source (output valid, kind, element_index, sample, last, input ready);
    modport sink   (input valid, kind, element_index, sample, last, output ready);
endinterface

[hw/rtl/ssee_dp.sv]
// Datapath: coefficient memory, state registers, shared MAC and round/saturate stages.
`include "assert_macros.svh"
module ssee_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssee_pkg::t_dp_ctrl i_ctl,
    input  ssee_pkg::t_dims    i_dims,
    input  ssee_pkg::t_wr      i_wr,
    input  logic [15:0]        i_dt,
    output ssee_pkg::t_result  o_res
);

    logic [15:0]                       r_cmem [ssee_pkg::COEF_COUNT];
    logic [ssee_pkg::COEF_COUNT-1:0]   r_cvld;
    logic signed [15:0]                r_crd;
    logic                              r_cok;
    logic signed [31:0]                r_opnd;
    logic signed [31:0]                n_opnd;
    logic                              r_v1;
    logic                              r_v2;
    logic signed [ssee_pkg::PROD_W-1:0] r_prod;
    logic signed [ssee_pkg::ACC_W-1:0]  r_acc;
    logic signed [31:0]                r_t32;
    logic signed [ssee_pkg::XD_W-1:0]  r_dtprod;
    logic signed [32:0]                r_inc;
    logic signed [31:0]                r_x  [ssee_pkg::MAX_STATES];
    logic signed [31:0]                r_xn [ssee_pkg::MAX_STATES];
    logic signed [31:0]                r_ua;
    logic signed [31:0]                r_ub;
    logic [ssee_pkg::CA_W-1:0]         rd_addr;
    logic                              issue;
    logic signed [15:0]                coef;
    logic signed [ssee_pkg::XD_W-1:0]  inc_full;
    logic signed [33:0]                x_sum;
    logic                              coef_wr;
    logic                              is_emit_x;

    localparam int CA = ssee_pkg::CA_W;

    // operand and coefficient address for the issue ops
    always_comb begin
        issue   = 1'b0;
        rd_addr = '0;
        n_opnd  = r_ua;
        case (i_ctl.op)
            ssee_pkg::OP_ISS_A: begin
                issue   = 1'b1;
                rd_addr = CA'(ssee_pkg::A_BASE) + CA'(i_ctl.i) * CA'(ssee_pkg::MAX_STATES)
                          + CA'(i_ctl.j);
                n_opnd  = r_x[i_ctl.j];
            end
            ssee_pkg::OP_ISS_B: begin
                issue   = 1'b1;
                rd_addr = CA'(ssee_pkg::B_BASE) + CA'(i_ctl.i) * CA'(ssee_pkg::MAX_DRIVES)
                          + CA'(i_ctl.j);
                n_opnd  = i_ctl.j[0] ? r_ub : r_ua;
            end
            ssee_pkg::OP_ISS_C: begin
                issue   = 1'b1;
                rd_addr = CA'(ssee_pkg::C_BASE) + CA'(i_ctl.i) * CA'(ssee_pkg::MAX_STATES)
                          + CA'(i_ctl.j);
                n_opnd  = r_x[i_ctl.j];
            end
            ssee_pkg::OP_ISS_D: begin
                issue   = 1'b1;
                rd_addr = CA'(ssee_pkg::D_BASE) + CA'(i_ctl.i) * CA'(ssee_pkg::MAX_DRIVES)
                          + CA'(i_ctl.j);
                n_opnd  = i_ctl.j[0] ? r_ub : r_ua;
            end
            default: ;
        endcase
    end

    assign coef     = r_cok ? r_crd : '0;  // never-written entries read as zero
    assign inc_full = (r_dtprod + ssee_pkg::XD_HALF) >>> 16;
    assign x_sum    = 34'(r_x[i_ctl.i]) + 34'(r_inc);
    assign coef_wr  = i_wr.coef_we && (int'(i_wr.coef_idx) < ssee_pkg::COEF_COUNT);

    // coefficient memory, registered read
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            r_cmem[i_wr.coef_idx] <= i_wr.coef_val;
        end
        if (issue) begin
            r_crd <= r_cmem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            for (int k = 0; k < ssee_pkg::MAX_STATES; k++) begin
                r_x[k] <= '0;
            end
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (coef_wr) begin
                r_cvld[i_wr.coef_idx] <= 1'b1;
            end
            if (i_wr.state_we && (int'(i_wr.state_idx) < ssee_pkg::MAX_STATES)) begin
                r_x[i_wr.state_idx] <= i_wr.state_val;
            end
            if (i_ctl.op == ssee_pkg::OP_COMMIT) begin
                for (int k = 0; k < ssee_pkg::MAX_STATES; k++) begin
                    if (k < int'(i_dims.n)) begin
                        r_x[k] <= r_xn[k];
                    end
                end
            end
        end
    end

    // MAC pipe: issue -> product -> accumulate; then the Euler update stages
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_opnd <= n_opnd;
            r_cok  <= r_cvld[rd_addr];
        end
        r_prod <= ssee_pkg::PROD_W'(coef) * ssee_pkg::PROD_W'(r_opnd);
        if (i_ctl.op == ssee_pkg::OP_CLR || i_ctl.op == ssee_pkg::OP_RND) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ssee_pkg::ACC_W'(r_prod);
        end
        if (i_ctl.op == ssee_pkg::OP_RND) begin
            r_t32 <= ssee_pkg::sat_rnd12(r_acc);
        end
        if (i_ctl.op == ssee_pkg::OP_DTMUL) begin
            r_dtprod <= ssee_pkg::XD_W'(r_t32) * ssee_pkg::XD_W'($signed({1'b0, i_dt}));
        end
        if (i_ctl.op == ssee_pkg::OP_INC) begin
            r_inc <= inc_full[32:0];
        end
        if (i_ctl.op == ssee_pkg::OP_UPD) begin
            r_xn[i_ctl.i] <= ssee_pkg::sat_x34(x_sum);
        end
        if (i_wr.drive_ld) begin
            r_ua <= i_wr.drive_a;
            r_ub <= i_wr.drive_b;
        end
    end

    assign is_emit_x    = (i_ctl.op == ssee_pkg::OP_EMIT_X);
    assign o_res.emit   = is_emit_x || (i_ctl.op == ssee_pkg::OP_EMIT_Y);
    assign o_res.kind   = is_emit_x;
    assign o_res.idx    = i_ctl.i;
    assign o_res.sample = is_emit_x ? r_x[i_ctl.i] : r_t32;
    assign o_res.last   = is_emit_x
                          && ((ssee_pkg::N_W'(i_ctl.i) + ssee_pkg::N_W'(1)) == i_dims.n);

    `ASSERT_CHK(a_mac_pipe, r_v2 |-> $past(r_v1), "MAC accumulate without a product")

endmodule

[hw/rtl/ssee_seq.sv]
// Microcode sequencer: step counter, loop counters and the control ROM.
`include "assert_macros.svh"
module ssee_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_out_free,
    input  ssee_pkg::t_dims    i_dims,
    output ssee_pkg::t_dp_ctrl o_ctl,
    output logic               o_idle
);

    localparam int UW = ssee_pkg::UPC_W;
    localparam int NW = ssee_pkg::N_W;

    localparam logic [UW-1:0] S_IDLE   = 5'd0;
    localparam logic [UW-1:0] S_XA     = 5'd1;
    localparam logic [UW-1:0] S_XB     = 5'd2;
    localparam logic [UW-1:0] S_XDR0   = 5'd3;
    localparam logic [UW-1:0] S_XDR1   = 5'd4;
    localparam logic [UW-1:0] S_XRND   = 5'd5;
    localparam logic [UW-1:0] S_XMUL   = 5'd6;
    localparam logic [UW-1:0] S_XINC   = 5'd7;
    localparam logic [UW-1:0] S_XUPD   = 5'd8;
    localparam logic [UW-1:0] S_COMMIT = 5'd9;
    localparam logic [UW-1:0] S_YC     = 5'd10;
    localparam logic [UW-1:0] S_YD     = 5'd11;
    localparam logic [UW-1:0] S_YDR0   = 5'd12;
    localparam logic [UW-1:0] S_YDR1   = 5'd13;
    localparam logic [UW-1:0] S_YRND   = 5'd14;
    localparam logic [UW-1:0] S_YEMIT  = 5'd15;
    localparam logic [UW-1:0] S_XEMIT  = 5'd16;
    localparam logic [UW-1:0] S_END    = 5'd17;

    logic [UW-1:0]              r_upc;
    logic [UW-1:0]              n_upc;
    logic [ssee_pkg::IDX_W-1:0] r_i;
    logic [ssee_pkg::IDX_W-1:0] n_i;
    logic [ssee_pkg::IDX_W-1:0] r_j;
    logic [ssee_pkg::IDX_W-1:0] n_j;
    ssee_pkg::t_ucode           uw;
    logic                       is_emit;
    logic                       hold;
    logic                       j_end_n;
    logic                       j_end_m;
    logic                       i_end_n;
    logic                       i_end_p;

    function automatic ssee_pkg::t_ucode uc(input logic [ssee_pkg::OP_W-1:0] op,
                                            input logic [ssee_pkg::CND_W-1:0] cnd,
                                            input logic [UW-1:0] tgt);
        ssee_pkg::t_ucode w;
        w.op     = op;
        w.cond   = cnd;
        w.target = tgt;
        return w;
    endfunction

    // control program of one step
    function automatic ssee_pkg::t_ucode rom(input logic [UW-1:0] a);
        ssee_pkg::t_ucode w;
        unique case (a)
            S_IDLE:   w = uc(ssee_pkg::OP_CLR,    ssee_pkg::CND_GO,   S_IDLE);
            S_XA:     w = uc(ssee_pkg::OP_ISS_A,  ssee_pkg::CND_JN,   S_XA);
            S_XB:     w = uc(ssee_pkg::OP_ISS_B,  ssee_pkg::CND_JM,   S_XB);
            S_XDR0:   w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_NEXT, S_IDLE);
            S_XDR1:   w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_NEXT, S_IDLE);
            S_XRND:   w = uc(ssee_pkg::OP_RND,    ssee_pkg::CND_NEXT, S_IDLE);
            S_XMUL:   w = uc(ssee_pkg::OP_DTMUL,  ssee_pkg::CND_NEXT, S_IDLE);
            S_XINC:   w = uc(ssee_pkg::OP_INC,    ssee_pkg::CND_NEXT, S_IDLE);
            S_XUPD:   w = uc(ssee_pkg::OP_UPD,    ssee_pkg::CND_IN,   S_XA);
            S_COMMIT: w = uc(ssee_pkg::OP_COMMIT, ssee_pkg::CND_NEXT, S_IDLE);
            S_YC:     w = uc(ssee_pkg::OP_ISS_C,  ssee_pkg::CND_JN,   S_YC);
            S_YD:     w = uc(ssee_pkg::OP_ISS_D,  ssee_pkg::CND_JM,   S_YD);
            S_YDR0:   w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_NEXT, S_IDLE);
            S_YDR1:   w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_NEXT, S_IDLE);
            S_YRND:   w = uc(ssee_pkg::OP_RND,    ssee_pkg::CND_NEXT, S_IDLE);
            S_YEMIT:  w = uc(ssee_pkg::OP_EMIT_Y, ssee_pkg::CND_IP,   S_YC);
            S_XEMIT:  w = uc(ssee_pkg::OP_EMIT_X, ssee_pkg::CND_IN,   S_XEMIT);
            S_END:    w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_JMP,  S_IDLE);
            default:  w = uc(ssee_pkg::OP_NOP,    ssee_pkg::CND_JMP,  S_IDLE);
        endcase
        return w;
    endfunction

    assign uw      = rom(r_upc);
    assign is_emit = (uw.op == ssee_pkg::OP_EMIT_Y) || (uw.op == ssee_pkg::OP_EMIT_X);
    assign hold    = is_emit && !i_out_free;
    assign j_end_n = (NW'(r_j) + NW'(1)) == i_dims.n;
    assign j_end_m = (NW'(r_j) + NW'(1)) == i_dims.m;
    assign i_end_n = (NW'(r_i) + NW'(1)) == i_dims.n;
    assign i_end_p = (NW'(r_i) + NW'(1)) == i_dims.p;

    always_comb begin
        n_upc = r_upc + UW'(1);
        n_i   = r_i;
        n_j   = r_j;
        if (hold) begin
            n_upc = r_upc;
        end else begin
            unique case (uw.cond)
                ssee_pkg::CND_NEXT: ;
                ssee_pkg::CND_GO: begin
                    if (!i_start) n_upc = uw.target;
                end
                ssee_pkg::CND_JN: begin
                    if (j_end_n) begin
                        n_j = '0;
                    end else begin
                        n_j   = r_j + 1'b1;
                        n_upc = uw.target;
                    end
                end
                ssee_pkg::CND_JM: begin
                    if (j_end_m) begin
                        n_j = '0;
                    end else begin
                        n_j   = r_j + 1'b1;
                        n_upc = uw.target;
                    end
                end
                ssee_pkg::CND_IN: begin
                    n_j = '0;
                    if (i_end_n) begin
                        n_i = '0;
                    end else begin
                        n_i   = r_i + 1'b1;
                        n_upc = uw.target;
                    end
                end
                ssee_pkg::CND_IP: begin
                    n_j = '0;
                    if (i_end_p) begin
                        n_i = '0;
                    end else begin
                        n_i   = r_i + 1'b1;
                        n_upc = uw.target;
                    end
                end
                ssee_pkg::CND_JMP: n_upc = uw.target;
                default:           n_upc = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
            r_i   <= '0;
            r_j   <= '0;
        end else begin
            r_upc <= n_upc;
            r_i   <= n_i;
            r_j   <= n_j;
        end
    end

    assign o_ctl.op = uw.op;
    assign o_ctl.i  = r_i;
    assign o_ctl.j  = r_j;
    assign o_idle   = (r_upc == S_IDLE);

    `ASSERT_ANY(a_reset_idle, !i_rst_n |=> (r_upc == S_IDLE), "sequencer not idle after reset")
    `ASSERT_CHK(a_stall_holds, hold |=> ($stable(r_upc) && $stable(r_i)), "emit stall moved")
    `ASSERT_CHK(a_idle_clear, (r_upc == S_IDLE) |-> (r_i == '0 && r_j == '0), "dirty counters")

endmodule

[hw/rtl/state_space_euler_step_top.sv]
// Top level of the fixed-point state-space forward Euler stepper.
//
// Usage:
//   i_in carries command words. action 0 writes one Q4.12 coefficient
//   (A, B, C, D packed row-major), action 1 loads one Q16.16 state
//   element, action 2 runs one Euler step with drives drive_a/drive_b.
//   Writes finish in the accept cycle; action 3 is dropped.
//   o_out carries the result words of a step: the outputs y first
//   (kind 0), then the new states x (kind 1); last marks the final word.
//   The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets dt and the
//   active sizes n, m, p; write it only while the block is idle.
// Timing:
//   One command at a time; i_in.ready is high while the sequencer is idle.
//   A step's length is set by the single shared multiply-accumulate unit,
//   which takes one coefficient per cycle, and by any receiver stalls.
//   A stalled output word parks in the output register; the sequencer
//   waits on its emit step until the register frees.
// Reset:
//   Synchronous, active low: coefficients and states read as zero,
//   dt = 655, n = 4, m = 2, p = 4; the block is ready the next cycle.
module state_space_euler_step_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssee_in_if.sink     i_in,
    ssee_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // config register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_STATES    = 2'd1;
    localparam logic [1:0] CFG_DRIVES    = 2'd2;
    localparam logic [1:0] CFG_OUTPUTS   = 2'd3;

    // command codes
    localparam logic [1:0] ACT_COEF  = 2'd0;
    localparam logic [1:0] ACT_STATE = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    logic [15:0]        r_dt;
    logic [2:0]         r_nst;
    logic [1:0]         r_ndr;
    logic [2:0]         r_nout;
    ssee_pkg::t_dims    dims;
    ssee_pkg::t_wr      wr;
    ssee_pkg::t_dp_ctrl ctl;
    ssee_pkg::t_result  res;
    ssee_pkg::t_result  r_ores;
    logic               r_ovalid;
    logic               idle;
    logic               in_acc;
    logic               start;
    logic               out_free;
    logic               emit_fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= 16'd655;
            r_nst  <= 3'd4;
            r_ndr  <= 2'd2;
            r_nout <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP: r_dt   <= i_cfg_data;
                CFG_STATES:    r_nst  <= i_cfg_data[2:0];
                CFG_DRIVES:    r_ndr  <= i_cfg_data[1:0];
                CFG_OUTPUTS:   r_nout <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // zero counts act as one, oversized ones as the maximum
    assign dims.n = ssee_pkg::clamp_count(r_nst, ssee_pkg::MAX_STATES);
    assign dims.m = ssee_pkg::clamp_count(ssee_pkg::N_W'(r_ndr), ssee_pkg::MAX_DRIVES);
    assign dims.p = ssee_pkg::clamp_count(r_nout, ssee_pkg::MAX_OUTPUTS);

    // input side
    assign i_in.ready = idle;
    assign in_acc     = i_in.valid && idle;
    assign start      = in_acc && (i_in.action == ACT_STEP);

    assign wr.coef_we   = in_acc && (i_in.action == ACT_COEF);
    assign wr.coef_idx  = i_in.coef_index;
    assign wr.coef_val  = i_in.coef_value;
    assign wr.state_we  = in_acc && (i_in.action == ACT_STATE);
    assign wr.state_idx = i_in.state_index;
    assign wr.state_val = i_in.state_value;
    assign wr.drive_ld  = start;
    assign wr.drive_a   = i_in.drive_a;
    assign wr.drive_b   = i_in.drive_b;

    ssee_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_dims     (dims),
        .o_ctl      (ctl),
        .o_idle     (idle)
    );

    ssee_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_dims  (dims),
        .i_wr    (wr),
        .i_dt    (r_dt),
        .o_res   (res)
    );

    // output register: frees when empty or when the receiver takes the word
    assign out_free  = !r_ovalid || o_out.ready;
    assign emit_fire = res.emit && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_ores <= res;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.kind          = r_ores.kind;
    assign o_out.element_index = r_ores.idx;
    assign o_out.sample        = r_ores.sample;
    assign o_out.last          = r_ores.last;

endmodule
